// ===== rtl/bba_pkg.sv =====
package bba_pkg;

  // map geometry
  localparam int MAP_BLOCKS = 1024;
  localparam int MAX_BATCH  = 16;
  localparam int WORD_W     = 32;
  localparam int ROWS       = MAP_BLOCKS / WORD_W;
  localparam int ROW_W      = $clog2(ROWS);
  localparam int BIT_W      = $clog2(WORD_W);

  // field and register widths
  localparam int IDX_W      = 10;
  localparam int NBLK_W     = 11;
  localparam int RF_W       = 10;
  localparam int RC_W       = 7;
  localparam int OP_W       = 2;
  localparam int COUNT_W    = 5;
  localparam int ST_W       = 2;
  localparam int CFG_W      = 11;
  localparam int CFG_IDX_W  = 2;

  // batch bookkeeping
  localparam int LEN_W      = $clog2(MAX_BATCH + 1);
  localparam int BL_W       = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;

  typedef enum logic [OP_W-1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_UNDO  = 2'd3
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_INIT_FAIL = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLOCK_COUNT    = 2'd0,
    CFG_RESERVED_FIRST = 2'd1,
    CFG_RESERVED_COUNT = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT_SET,
    S_ALLOC_RD,
    S_ALLOC_MOD,
    S_FREE_RD,
    S_FREE_MOD,
    S_UNDO_RD,
    S_UNDO_MOD,
    S_REPORT
  } state_t;

  // word modify unit
  typedef enum logic [1:0] {
    WOP_SET_FIRST,
    WOP_CLR_BIT,
    WOP_SET_MASK
  } wop_t;

  typedef struct packed {
    wop_t             op;
    logic             valid;
    logic [BIT_W-1:0] lo;
    logic [BIT_W-1:0] hi;
  } wcmd_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              full;
    logic [BIT_W-1:0]  free_bit;
  } wres_t;

endpackage

// ===== rtl/bba_in_if.sv =====
interface bba_in_if;
  logic                       valid;
  logic                       ready;
  logic [bba_pkg::OP_W-1:0]    op;
  logic [bba_pkg::COUNT_W-1:0] count;
  logic [bba_pkg::IDX_W-1:0]   block_index;

  modport source (output valid, op, count, block_index, input ready);
  modport sink   (input valid, op, count, block_index, output ready);
endinterface

// ===== rtl/bba_out_if.sv =====
interface bba_out_if;
  logic                     valid;
  logic                     ready;
  logic [bba_pkg::IDX_W-1:0] block;
  logic [bba_pkg::ST_W-1:0]  status;
  logic                     last;

  modport source (output valid, block, status, last, input ready);
  modport sink   (input valid, block, status, last, output ready);
endinterface

// ===== rtl/bitmap_block_allocator.sv =====
// First-fit bitmap block allocator. The used map lives in a RAM of 32 rows of
// 32 bits; a per-row "full" flag picks the lowest row with a free block
// combinationally, and one shared word unit finds the free bit and writes the
// row back. Per-row valid flags are cleared at reset and by init, so there is
// no clearing pass. Allocate reads a row, then modifies and writes it back
// through the RAM port, for each block; free reads the row, modifies and writes
// it back, then reports; undo does the same for each block of the last batch,
// then reports; init writes each map row touched by the reserved run (at most
// 5), then reports. Allocate with count zero gives no result. The input is held
// off while an item is in progress; one output register holds a result until
// taken, and a waiting result stalls the sequence. Configuration is taken at
// any time but must only change between items.
module bitmap_block_allocator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [bba_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bba_pkg::CFG_W-1:0]       cfg_data,
  bba_in_if.sink                          req,
  bba_out_if.source                       rsp
);

  // configuration
  logic [bba_pkg::NBLK_W-1:0] block_count;
  logic [bba_pkg::RF_W-1:0]   reserved_first;
  logic [bba_pkg::RC_W-1:0]   reserved_count;

  // sequencer
  bba_pkg::state_t            state, state_next;
  logic [bba_pkg::ROW_W-1:0]  row, row_next;
  logic [bba_pkg::BIT_W-1:0]  bit_sel, bit_sel_next;
  logic [bba_pkg::LEN_W-1:0]  target, target_next;
  logic [bba_pkg::LEN_W-1:0]  len, len_next;
  logic [bba_pkg::BL_W-1:0]   uidx, uidx_next;
  bba_pkg::status_t           rep_status, rep_status_next;

  // map bookkeeping
  logic [bba_pkg::ROWS-1:0]   row_valid;
  logic [bba_pkg::ROWS-1:0]   full;
  logic [bba_pkg::IDX_W-1:0]  blist [bba_pkg::MAX_BATCH];
  logic                       blist_we;
  logic                       map_clear;
  logic                       ram_we;
  logic [bba_pkg::ROW_W-1:0]  ram_raddr;
  logic [bba_pkg::WORD_W-1:0] ram_rdata;
  bba_pkg::wcmd_t             wcmd;
  bba_pkg::wres_t             wres;

  // output register
  logic                       out_valid;
  logic [bba_pkg::IDX_W-1:0]  out_block;
  bba_pkg::status_t           out_status;
  logic                       out_last;
  logic                       emit;
  logic [bba_pkg::IDX_W-1:0]  emit_block;
  bba_pkg::status_t           emit_status;
  logic                       emit_last;
  logic                       out_free;

  // derived values
  logic [bba_pkg::NBLK_W-1:0] n_eff;
  logic [bba_pkg::NBLK_W-1:0] run_top;
  logic [bba_pkg::NBLK_W-1:0] run_end;
  logic [bba_pkg::ROW_W-1:0]  first_row;
  logic [bba_pkg::ROW_W-1:0]  end_row;
  logic [bba_pkg::ROW_W-1:0]  free_row;
  logic [bba_pkg::LEN_W-1:0]  count_sat;
  logic [bba_pkg::IDX_W-1:0]  alloc_b;
  logic [bba_pkg::IDX_W-1:0]  undo_b;
  logic                       alloc_done;

  assign n_eff = (block_count > bba_pkg::NBLK_W'(bba_pkg::MAP_BLOCKS)) ?
                 bba_pkg::NBLK_W'(bba_pkg::MAP_BLOCKS) : block_count;

  // reserved run [first, top), last block at run_end
  assign run_top   = bba_pkg::NBLK_W'(reserved_first) + bba_pkg::NBLK_W'(reserved_count);
  assign run_end   = run_top - bba_pkg::NBLK_W'(1);
  assign first_row = reserved_first[bba_pkg::RF_W-1 -: bba_pkg::ROW_W];
  assign end_row   = run_end[bba_pkg::BIT_W +: bba_pkg::ROW_W];

  assign count_sat = (32'(req.count) > 32'(bba_pkg::MAX_BATCH)) ?
                     bba_pkg::LEN_W'(bba_pkg::MAX_BATCH) : bba_pkg::LEN_W'(req.count);

  assign alloc_b    = {row, wres.free_bit};
  assign alloc_done = (len + bba_pkg::LEN_W'(1)) == target;
  assign undo_b     = blist[uidx];
  assign out_free   = !out_valid || rsp.ready;

  // lowest row that still holds a free block
  always_comb begin
    free_row = '0;
    for (int r = bba_pkg::ROWS - 1; r >= 0; r--) begin
      if (!full[r]) begin
        free_row = bba_pkg::ROW_W'(r);
      end
    end
  end

  bba_ram #(
    .WIDTH (bba_pkg::WORD_W),
    .DEPTH (bba_pkg::ROWS)
  ) map_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (row),
    .wdata (wres.word),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bba_word_unit word_unit (
    .cmd   (wcmd),
    .rdata (ram_rdata),
    .res   (wres)
  );

  assign req.ready  = (state == bba_pkg::S_IDLE);
  assign rsp.valid  = out_valid;
  assign rsp.block  = out_block;
  assign rsp.status = out_status;
  assign rsp.last   = out_last;

  // state register and control
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= bba_pkg::S_IDLE;
      len            <= '0;
      row_valid      <= '0;
      full           <= '0;
      out_valid      <= 1'b0;
      block_count    <= bba_pkg::NBLK_W'(1024);
      reserved_first <= '0;
      reserved_count <= '0;
    end else begin
      state <= state_next;
      len   <= len_next;
      if (map_clear) begin
        row_valid <= '0;
        full      <= '0;
      end else if (ram_we) begin
        row_valid[row] <= 1'b1;
        full[row]      <= wres.full;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (bba_pkg::cfg_idx_t'(cfg_index))
          bba_pkg::CFG_BLOCK_COUNT:    block_count    <= cfg_data[bba_pkg::NBLK_W-1:0];
          bba_pkg::CFG_RESERVED_FIRST: reserved_first <= cfg_data[bba_pkg::RF_W-1:0];
          bba_pkg::CFG_RESERVED_COUNT: reserved_count <= cfg_data[bba_pkg::RC_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    row        <= row_next;
    bit_sel    <= bit_sel_next;
    target     <= target_next;
    uidx       <= uidx_next;
    rep_status <= rep_status_next;
    if (blist_we) begin
      blist[len[bba_pkg::BL_W-1:0]] <= alloc_b;
    end
    if (emit) begin
      out_block  <= emit_block;
      out_status <= emit_status;
      out_last   <= emit_last;
    end
  end

  // sequencer
  always_comb begin
    state_next      = state;
    row_next        = row;
    bit_sel_next    = bit_sel;
    target_next     = target;
    len_next        = len;
    uidx_next       = uidx;
    rep_status_next = rep_status;
    ram_raddr       = row;
    ram_we          = 1'b0;
    map_clear       = 1'b0;
    blist_we        = 1'b0;
    emit            = 1'b0;
    emit_block      = '0;
    emit_status     = bba_pkg::ST_OK;
    emit_last       = 1'b1;
    wcmd.op         = bba_pkg::WOP_CLR_BIT;
    wcmd.valid      = row_valid[row];
    wcmd.lo         = bit_sel;
    wcmd.hi         = bit_sel;

    case (state)
      bba_pkg::S_IDLE: begin
        if (req.valid) begin
          case (bba_pkg::op_t'(req.op))
            bba_pkg::OP_INIT: begin
              if (run_top > n_eff) begin
                rep_status_next = bba_pkg::ST_INIT_FAIL;
                state_next      = bba_pkg::S_REPORT;
              end else begin
                map_clear       = 1'b1;
                rep_status_next = bba_pkg::ST_OK;
                row_next        = first_row;
                state_next      = (reserved_count == '0) ? bba_pkg::S_REPORT
                                                         : bba_pkg::S_INIT_SET;
              end
            end
            bba_pkg::OP_ALLOC: begin
              len_next    = '0;
              target_next = count_sat;
              // zero count: empty batch, no transaction out
              if (count_sat != '0) begin
                state_next = bba_pkg::S_ALLOC_RD;
              end
            end
            bba_pkg::OP_FREE: begin
              if (bba_pkg::NBLK_W'(req.block_index) >= n_eff) begin
                rep_status_next = bba_pkg::ST_RANGE;
                state_next      = bba_pkg::S_REPORT;
              end else begin
                rep_status_next = bba_pkg::ST_OK;
                row_next        = req.block_index[bba_pkg::IDX_W-1 -: bba_pkg::ROW_W];
                bit_sel_next    = req.block_index[bba_pkg::BIT_W-1:0];
                state_next      = bba_pkg::S_FREE_RD;
              end
            end
            bba_pkg::OP_UNDO: begin
              rep_status_next = bba_pkg::ST_OK;
              uidx_next       = '0;
              state_next      = (len == '0) ? bba_pkg::S_REPORT : bba_pkg::S_UNDO_RD;
            end
            default: ;
          endcase
        end
      end

      bba_pkg::S_INIT_SET: begin
        // fresh row after the clear: write the slice of the run in this row
        wcmd.op    = bba_pkg::WOP_SET_MASK;
        wcmd.lo    = (row == first_row) ? reserved_first[bba_pkg::BIT_W-1:0] : '0;
        wcmd.hi    = (row == end_row) ? run_end[bba_pkg::BIT_W-1:0] : '1;
        ram_we     = 1'b1;
        if (row == end_row) begin
          state_next = bba_pkg::S_REPORT;
        end else begin
          row_next = row + bba_pkg::ROW_W'(1);
        end
      end

      bba_pkg::S_ALLOC_RD: begin
        if (&full) begin
          rep_status_next = bba_pkg::ST_FULL;
          state_next      = bba_pkg::S_REPORT;
        end else begin
          ram_raddr  = free_row;
          row_next   = free_row;
          state_next = bba_pkg::S_ALLOC_MOD;
        end
      end

      bba_pkg::S_ALLOC_MOD: begin
        wcmd.op = bba_pkg::WOP_SET_FIRST;
        if (out_free) begin
          emit = 1'b1;
          if (bba_pkg::NBLK_W'(alloc_b) >= n_eff) begin
            // lowest free block lies past the managed range
            emit_status = bba_pkg::ST_FULL;
            state_next  = bba_pkg::S_IDLE;
          end else begin
            ram_we     = 1'b1;
            blist_we   = 1'b1;
            len_next   = len + bba_pkg::LEN_W'(1);
            emit_block = alloc_b;
            emit_last  = alloc_done;
            state_next = alloc_done ? bba_pkg::S_IDLE : bba_pkg::S_ALLOC_RD;
          end
        end
      end

      bba_pkg::S_FREE_RD: begin
        state_next = bba_pkg::S_FREE_MOD;
      end

      bba_pkg::S_FREE_MOD: begin
        ram_we     = 1'b1;
        state_next = bba_pkg::S_REPORT;
      end

      bba_pkg::S_UNDO_RD: begin
        row_next     = undo_b[bba_pkg::IDX_W-1 -: bba_pkg::ROW_W];
        bit_sel_next = undo_b[bba_pkg::BIT_W-1:0];
        ram_raddr    = undo_b[bba_pkg::IDX_W-1 -: bba_pkg::ROW_W];
        state_next   = bba_pkg::S_UNDO_MOD;
      end

      bba_pkg::S_UNDO_MOD: begin
        ram_we = 1'b1;
        if ((bba_pkg::LEN_W'(uidx) + bba_pkg::LEN_W'(1)) == len) begin
          len_next   = '0;
          state_next = bba_pkg::S_REPORT;
        end else begin
          uidx_next  = uidx + bba_pkg::BL_W'(1);
          state_next = bba_pkg::S_UNDO_RD;
        end
      end

      bba_pkg::S_REPORT: begin
        if (out_free) begin
          emit        = 1'b1;
          emit_status = rep_status;
          state_next  = bba_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = bba_pkg::S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // the row picked for allocation must have had a free block
  a_alloc_row_not_full: assert property (@(posedge clk) disable iff (rst)
    (state == bba_pkg::S_ALLOC_MOD) |-> !full[row])
    else $error("allocation picked a full row");

  // a written row is live afterwards, so later reads see its data
  a_row_valid_after_write: assert property (@(posedge clk) disable iff (rst)
    (ram_we && !map_clear) |=> row_valid[$past(row)])
    else $error("written row not marked valid");

  // an allocated block handed out lies within the managed range
  a_block_in_range: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.status == bba_pkg::ST_OK) && (rsp.block != '0))
      |-> (bba_pkg::NBLK_W'(rsp.block) < n_eff))
    else $error("allocated block beyond block count");
`endif

endmodule

// ===== rtl/bba_ram.sv =====
module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/bba_word_unit.sv =====
// Shared modify unit for one map word: first-free search, bit set/clear, run mask.
module bba_word_unit (
  input  bba_pkg::wcmd_t                cmd,
  input  logic [bba_pkg::WORD_W-1:0]    rdata,
  output bba_pkg::wres_t                res
);

  logic [bba_pkg::WORD_W-1:0] cur;
  logic [bba_pkg::WORD_W-1:0] mask;
  logic [bba_pkg::WORD_W-1:0] nw;
  logic [bba_pkg::BIT_W-1:0]  free_bit;

  always_comb begin
    // a row never written since the last clear reads as all free
    cur = cmd.valid ? rdata : '0;

    free_bit = '0;
    for (int i = bba_pkg::WORD_W - 1; i >= 0; i--) begin
      if (!cur[i]) begin
        free_bit = bba_pkg::BIT_W'(i);
      end
    end

    mask = ({bba_pkg::WORD_W{1'b1}} << cmd.lo) &
           ({bba_pkg::WORD_W{1'b1}} >> (bba_pkg::BIT_W'(bba_pkg::WORD_W - 1) - cmd.hi));

    case (cmd.op)
      bba_pkg::WOP_SET_FIRST: nw = cur | (bba_pkg::WORD_W'(1) << free_bit);
      bba_pkg::WOP_CLR_BIT:   nw = cur & ~(bba_pkg::WORD_W'(1) << cmd.lo);
      bba_pkg::WOP_SET_MASK:  nw = cur | mask;
      default:                nw = cur;
    endcase

    res.word     = nw;
    res.full     = &nw;
    res.free_bit = free_bit;
  end

endmodule
